### rtl/core/nntp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and character classes for the note name text parser.
// No dependencies.
package nntp_pkg;

	localparam int CharW   = 8;
	localparam int NoteW   = 7;
	localparam int StatusW = 3;
	localparam int OffsetW = 4;
	localparam int MagW    = 32;
	localparam int InDataW  = 8;
	localparam int OutDataW = 16;

	localparam logic [OffsetW-1:0] OctaveMax = 4'd10;
	localparam logic [7:0]         NoteMax   = 8'd127;
	localparam logic [MagW+2:0]    MagLimit  = 35'd2147483648;
	localparam logic [CharW-1:0]   ChSharp   = 8'h23;
	localparam logic [CharW-1:0]   ChMinus   = 8'h2d;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_LETTER = 3'd1,
		PH_SHARP  = 3'd2,
		PH_SIGN   = 3'd3,
		PH_DIGITS = 3'd4,
		PH_TAIL   = 3'd5,
		PH_ERROR  = 3'd6
	} phase_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_LETTER   = 3'd2,
		ST_NOOCT    = 3'd3,
		ST_BADOCT   = 3'd4,
		ST_OCTRANGE = 3'd5,
		ST_TRAIL    = 3'd6,
		ST_NOTE     = 3'd7
	} status_t;

	function automatic logic is_space(input logic [CharW-1:0] c);
		return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
	endfunction

	function automatic logic is_digit(input logic [CharW-1:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	// pitch class of a letter; valid is low for anything else
	function automatic logic [OffsetW:0] letter_class(input logic [CharW-1:0] c);
		logic [OffsetW:0] r;
		case (c | 8'h20)
			8'h61: r = {1'b1, 4'd9};
			8'h62: r = {1'b1, 4'd11};
			8'h63: r = {1'b1, 4'd0};
			8'h64: r = {1'b1, 4'd2};
			8'h65: r = {1'b1, 4'd4};
			8'h66: r = {1'b1, 4'd5};
			8'h67: r = {1'b1, 4'd7};
			default: r = '0;
		endcase
		if (c[7] || c < 8'h41)
			r = '0;
		return r;
	endfunction

endpackage

### rtl/core/note_name_text_parser_unit.sv
`timescale 1ns / 1ps
// Note name text parser: character stream in, note number and status out.
// Depends on nntp_pkg.
//
// Accepts one character request per cycle. Each character is registered in
// the input register, then updates the parse state; an end-of-text request
// (s_tlast high) loads the result register as it leaves the input register,
// and m_tvalid rises once that register is loaded. The input side stalls only
// when an end-of-text request reaches the parse stage while an earlier result
// is still held in the result register; plain characters keep flowing
// meanwhile.
module note_name_text_parser_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [nntp_pkg::InDataW-1:0]  s_tdata,   // [7:0] text_char
	input  logic                          s_tlast,   // end_of_text
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [nntp_pkg::OutDataW-1:0] m_tdata    // [6:0] note_number, [9:7] status, zero pad
);
	import nntp_pkg::*;

	logic               valid_s1;
	logic [CharW-1:0]   char_s1;
	logic               eot_s1;

	phase_t             phase_q, phase_d;
	logic [OffsetW-1:0] offset_q, offset_d;
	logic               neg_q, neg_d;
	logic [MagW-1:0]    mag_q, mag_d;
	logic               ovf_q, ovf_d;
	logic               trail_q, trail_d;
	status_t            err_q, err_d;

	logic               out_valid_q;
	logic [NoteW-1:0]   out_note_q;
	status_t            out_status_q;

	logic               out_free, adv;
	logic [MagW+2:0]    mag_next;
	logic [OffsetW:0]   cls;
	logic [7:0]         note_sum;
	status_t            res_status;
	logic [NoteW-1:0]   res_note;

	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && (!eot_s1 || out_free);
	assign s_tready = !valid_s1 || adv;

	assign mag_next = {mag_q, 3'b000} + {2'b00, mag_q, 1'b0}
		+ {31'd0, char_s1[3:0] - 4'd0};
	assign cls      = letter_class(char_s1);
	assign note_sum = 8'(mag_q[3:0]) * 8'd12 + 8'(offset_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata[CharW-1:0];
			eot_s1  <= s_tlast;
		end
	end

	always_comb begin
		res_status = ST_OK;
		res_note   = '0;
		case (phase_q)
			PH_LEAD:   res_status = ST_EMPTY;
			PH_LETTER: res_status = ST_NOOCT;
			PH_SHARP:  res_status = ST_NOOCT;
			PH_SIGN:   res_status = ST_BADOCT;
			PH_DIGITS, PH_TAIL: begin
				if (ovf_q || (!neg_q && mag_q[MagW-1]))
					res_status = ST_BADOCT;
				else if ((neg_q && mag_q != '0) || mag_q > MagW'(OctaveMax))
					res_status = ST_OCTRANGE;
				else if (trail_q)
					res_status = ST_TRAIL;
				else if (note_sum > NoteMax)
					res_status = ST_NOTE;
				else
					res_note = note_sum[NoteW-1:0];
			end
			default:   res_status = err_q;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		offset_d = offset_q;
		neg_d    = neg_q;
		mag_d    = mag_q;
		ovf_d    = ovf_q;
		trail_d  = trail_q;
		err_d    = err_q;
		if (adv && eot_s1) begin
			phase_d  = PH_LEAD;
			offset_d = '0;
			neg_d    = 1'b0;
			mag_d    = '0;
			ovf_d    = 1'b0;
			trail_d  = 1'b0;
			err_d    = ST_OK;
		end else if (adv) begin
			case (phase_q)
				PH_LEAD: begin
					if (!is_space(char_s1)) begin
						if (cls[OffsetW]) begin
							offset_d = cls[OffsetW-1:0];
							phase_d  = PH_LETTER;
						end else begin
							err_d   = ST_LETTER;
							phase_d = PH_ERROR;
						end
					end
				end
				PH_LETTER, PH_SHARP: begin
					if (phase_q == PH_LETTER && char_s1 == ChSharp) begin
						offset_d = offset_q + 4'd1;
						phase_d  = PH_SHARP;
					end else if (is_space(char_s1)) begin
						err_d   = ST_NOOCT;
						phase_d = PH_ERROR;
					end else if (char_s1 == ChMinus) begin
						neg_d   = 1'b1;
						phase_d = PH_SIGN;
					end else if (is_digit(char_s1)) begin
						if (!ovf_q) begin
							if (mag_next > MagLimit) ovf_d = 1'b1;
							else mag_d = mag_next[MagW-1:0];
						end
						phase_d = PH_DIGITS;
					end else begin
						err_d   = ST_BADOCT;
						phase_d = PH_ERROR;
					end
				end
				PH_SIGN: begin
					if (is_digit(char_s1)) begin
						if (!ovf_q) begin
							if (mag_next > MagLimit) ovf_d = 1'b1;
							else mag_d = mag_next[MagW-1:0];
						end
						phase_d = PH_DIGITS;
					end else begin
						err_d   = ST_BADOCT;
						phase_d = PH_ERROR;
					end
				end
				PH_DIGITS: begin
					if (is_digit(char_s1)) begin
						if (!ovf_q) begin
							if (mag_next > MagLimit) ovf_d = 1'b1;
							else mag_d = mag_next[MagW-1:0];
						end
					end else begin
						if (!is_space(char_s1)) trail_d = 1'b1;
						phase_d = PH_TAIL;
					end
				end
				PH_TAIL: begin
					if (!is_space(char_s1)) trail_d = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			offset_q <= '0;
			neg_q    <= 1'b0;
			mag_q    <= '0;
			ovf_q    <= 1'b0;
			trail_q  <= 1'b0;
			err_q    <= ST_OK;
		end else begin
			phase_q  <= phase_d;
			offset_q <= offset_d;
			neg_q    <= neg_d;
			mag_q    <= mag_d;
			ovf_q    <= ovf_d;
			trail_q  <= trail_d;
			err_q    <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && eot_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && eot_s1) begin
			out_note_q   <= res_note;
			out_status_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OutDataW - NoteW - StatusW){1'b0}}, out_status_q, out_note_q};

endmodule
